/* design/fhvp_pkg.sv */
// ----------------------------------------------------------------------------
// fhvp_pkg
// Types, codes and sizes shared by the frame header varint parser.
// ----------------------------------------------------------------------------
package fhvp_pkg;

	// Saturation bound of the byte counters and the width that holds it.
	localparam int unsigned MAX_BUFFER_BYTES = 65536;
	localparam int          CNT_W            = $clog2(MAX_BUFFER_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_BUFFER_BYTES);

	localparam int          ACC_W            = 62;
	localparam int          HDR_W            = 5;
	localparam logic [HDR_W-1:0] HDR_MAX     = 5'd16;
	localparam logic [7:0]  VARINT_LOW_MASK  = 8'h3F;

	// Parse phase, one-hot.
	typedef enum logic [2:0] {
		PH_TYPE = 3'b001,
		PH_LEN  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		CLS_TYPE     = 2'd0,
		CLS_LEN      = 2'd1,
		CLS_PAYLOAD  = 2'd2,
		CLS_TRAILING = 2'd3
	} byte_class_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_TRUNC     = 3'd2,
		ST_WRONG     = 3'd3,
		ST_MISMATCH  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       byte_class;
		logic [7:0]       out_byte;
		logic             done_res;
		logic [2:0]       status;
		logic [7:0]       frame_type;
		logic [HDR_W-1:0] header_bytes;
		logic [ACC_W-1:0] payload_length;
	} res_t;

endpackage

/* design/fhvp_in_if.sv */
// ----------------------------------------------------------------------------
// fhvp_in_if
// Byte channel into the parser: valid/ready handshake with byte and last mark.
// ----------------------------------------------------------------------------
interface fhvp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink   (input valid, input in_byte, input last, output ready);
endinterface

/* design/fhvp_out_if.sv */
// ----------------------------------------------------------------------------
// fhvp_out_if
// Result channel out of the parser: classed byte plus the end-of-buffer summary.
// ----------------------------------------------------------------------------
interface fhvp_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  byte_class;
	logic [7:0]                  out_byte;
	logic                        done_res;
	logic [2:0]                  status;
	logic [7:0]                  frame_type;
	logic [fhvp_pkg::HDR_W-1:0]  header_bytes;
	logic [fhvp_pkg::ACC_W-1:0]  payload_length;

	modport source (output valid, output byte_class, output out_byte, output done_res,
		output status, output frame_type, output header_bytes, output payload_length,
		input ready);
	modport sink   (input valid, input byte_class, input out_byte, input done_res,
		input status, input frame_type, input header_bytes, input payload_length,
		output ready);
endinterface

/* design/fhvp_parse.sv */
// ----------------------------------------------------------------------------
// fhvp_parse
// Parse state and the per-byte decode: varint assembly, byte classing and
// the end-of-buffer status. State advances on each step strobe.
// ----------------------------------------------------------------------------
module fhvp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               step,
	input  fhvp_pkg::in_item_t item,
	output fhvp_pkg::res_t     res
);

	logic [7:0]                  expected_type_q;
	fhvp_pkg::phase_t            phase_q, phase_n;
	logic [fhvp_pkg::ACC_W-1:0]  acc_q, acc_n;
	logic [2:0]                  left_q, left_n;
	logic [7:0]                  type_q, type_n;
	logic [fhvp_pkg::ACC_W-1:0]  len_q, len_n;
	logic [fhvp_pkg::HDR_W-1:0]  hdr_q, hdr_n;
	logic [fhvp_pkg::CNT_W-1:0]  pay_q, pay_n;
	logic [fhvp_pkg::CNT_W-1:0]  buf_q, buf_n;
	logic [1:0]                  cls;
	logic [2:0]                  status;
	logic                        pay_short, pay_short_n;

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		left_n  = left_q;
		type_n  = type_q;
		len_n   = len_q;
		hdr_n   = hdr_q;
		pay_n   = pay_q;
		buf_n   = (buf_q < fhvp_pkg::MAX_CNT) ? buf_q + 1'b1 : buf_q;
		cls     = fhvp_pkg::CLS_TRAILING;

		pay_short = {{(fhvp_pkg::ACC_W - fhvp_pkg::CNT_W){1'b0}}, pay_q} < len_q;

		if (phase_q == fhvp_pkg::PH_TYPE || phase_q == fhvp_pkg::PH_LEN) begin
			cls   = (phase_q == fhvp_pkg::PH_TYPE) ? fhvp_pkg::CLS_TYPE : fhvp_pkg::CLS_LEN;
			hdr_n = (hdr_q < fhvp_pkg::HDR_MAX) ? hdr_q + 1'b1 : hdr_q;
			if (left_q == 3'd0) begin
				// The two prefix bits select 1, 2, 4 or 8 bytes in all.
				acc_n  = fhvp_pkg::ACC_W'(item.in_byte & fhvp_pkg::VARINT_LOW_MASK);
				left_n = {item.in_byte[7] & item.in_byte[6], item.in_byte[7],
					item.in_byte[7] | item.in_byte[6]};
			end else begin
				acc_n  = {acc_q[fhvp_pkg::ACC_W-9:0], item.in_byte};
				left_n = left_q - 3'd1;
			end
			if (left_n == 3'd0) begin
				if (phase_q == fhvp_pkg::PH_TYPE) begin
					type_n  = acc_n[7:0];
					phase_n = fhvp_pkg::PH_LEN;
				end else begin
					len_n   = acc_n;
					phase_n = fhvp_pkg::PH_BODY;
				end
				acc_n = '0;
			end
		end else if (pay_short) begin
			cls   = fhvp_pkg::CLS_PAYLOAD;
			pay_n = (pay_q < fhvp_pkg::MAX_CNT) ? pay_q + 1'b1 : pay_q;
		end

		pay_short_n = {{(fhvp_pkg::ACC_W - fhvp_pkg::CNT_W){1'b0}}, pay_n} < len_n;

		// Status priority: too short, truncated, wrong type, length mismatch.
		if (buf_n < fhvp_pkg::CNT_W'(2))
			status = fhvp_pkg::ST_SHORT;
		else if (phase_n != fhvp_pkg::PH_BODY)
			status = fhvp_pkg::ST_TRUNC;
		else if (type_n != expected_type_q)
			status = fhvp_pkg::ST_WRONG;
		else if (pay_short_n)
			status = fhvp_pkg::ST_MISMATCH;
		else
			status = fhvp_pkg::ST_OK;

		res.byte_class     = cls;
		res.out_byte       = item.in_byte;
		res.done_res       = item.last;
		res.status         = item.last ? status : fhvp_pkg::ST_OK;
		res.frame_type     = (item.last && phase_n != fhvp_pkg::PH_TYPE) ? type_n : 8'd0;
		res.header_bytes   = item.last ? hdr_n : '0;
		res.payload_length = (item.last && phase_n == fhvp_pkg::PH_BODY) ? len_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_type_q <= 8'd0;
		end else if (cfg_we) begin
			expected_type_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fhvp_pkg::PH_TYPE;
			acc_q   <= '0;
			left_q  <= '0;
			type_q  <= '0;
			len_q   <= '0;
			hdr_q   <= '0;
			pay_q   <= '0;
			buf_q   <= '0;
		end else if (step) begin
			if (item.last) begin
				// The buffer ends here; rearm for the next one.
				phase_q <= fhvp_pkg::PH_TYPE;
				acc_q   <= '0;
				left_q  <= '0;
				type_q  <= '0;
				len_q   <= '0;
				hdr_q   <= '0;
				pay_q   <= '0;
				buf_q   <= '0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				left_q  <= left_n;
				type_q  <= type_n;
				len_q   <= len_n;
				hdr_q   <= hdr_n;
				pay_q   <= pay_n;
				buf_q   <= buf_n;
			end
		end
	end

endmodule

/* design/frame_header_varint_parser.sv */
// ----------------------------------------------------------------------------
// frame_header_varint_parser
// Streams one received buffer a byte per transfer, decodes the type and length
// varints of the frame header, classes and passes through every byte, and
// reports a status with type, header length and payload length on the last
// byte. It takes one byte per clock cycle while the output is not stalled. A
// byte transferred in lands in the input register, and the single decode step
// feeds the result register, from which the result is offered. While the
// previous result waits for its transfer, an empty input register can still
// take a new byte.
// ----------------------------------------------------------------------------
module frame_header_varint_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	fhvp_in_if.sink     in_ch,
	fhvp_out_if.source  out_ch
);

	fhvp_pkg::in_item_t item_s1;
	logic               vld_s1;
	fhvp_pkg::res_t     res;
	fhvp_pkg::res_t     res_s2;
	logic               vld_s2;
	logic               advance;

	assign advance     = vld_s1 && (!vld_s2 || out_ch.ready);
	assign in_ch.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.in_byte <= in_ch.in_byte;
			item_s1.last    <= in_ch.last;
		end
	end

	fhvp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid          = vld_s2;
	assign out_ch.byte_class     = res_s2.byte_class;
	assign out_ch.out_byte       = res_s2.out_byte;
	assign out_ch.done_res       = res_s2.done_res;
	assign out_ch.status         = res_s2.status;
	assign out_ch.frame_type     = res_s2.frame_type;
	assign out_ch.header_bytes   = res_s2.header_bytes;
	assign out_ch.payload_length = res_s2.payload_length;

	// Summary fields stay zero on bytes that do not end the buffer.
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !res_s2.done_res) |->
		(res_s2.status == fhvp_pkg::ST_OK && res_s2.frame_type == 8'd0 &&
		res_s2.header_bytes == '0 && res_s2.payload_length == '0))
		else $error("summary fields set on a byte that is not last");

	// A good frame always has at least one type and one length byte.
	a_ok_header: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.done_res && res_s2.status == fhvp_pkg::ST_OK) |->
		(res_s2.header_bytes >= 5'd2))
		else $error("ok status with a header under two bytes");

	// A truncated header never reports a payload length.
	a_trunc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.done_res && res_s2.status == fhvp_pkg::ST_TRUNC) |->
		(res_s2.payload_length == '0))
		else $error("payload length reported on truncated header");

	// With both stages full and the output stalled, no byte may enter.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken while pipeline is full and stalled");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame header varint parser. A table of short
// buffers covers the status codes and the varint extremes. Random buffers,
// mostly well formed, follow under three settings of the expected type and
// three mixes of sender and receiver idling. One buffer declares a length far
// beyond the bytes that follow it. Every output transfer is compared with a
// table row's result or a bit-accurate software decoder of the header.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [7:0]     b;
		logic           lst;
		bit             typed;
		fhvp_pkg::res_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	fhvp_in_if  in_ch ();
	fhvp_out_if out_ch ();

	frame_header_varint_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Decoder state, mirrored from the block.
	fhvp_pkg::phase_t           ph;
	logic [fhvp_pkg::ACC_W-1:0] acc;
	logic [2:0]                 acc_left;
	logic [7:0]                 seen_type;
	logic [fhvp_pkg::ACC_W-1:0] seen_len;
	logic [fhvp_pkg::HDR_W-1:0] hdr_cnt;
	logic [fhvp_pkg::CNT_W-1:0] pay_cnt;
	logic [fhvp_pkg::CNT_W-1:0] buf_cnt;
	logic [7:0]                 want_type;

	fhvp_pkg::res_t results_due[$];
	stim_row_t      dir_rows[$];
	int             errors;
	int             tx_idle_pct;
	int             rx_idle_pct;
	int             items_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("frame_header_varint_parser regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (errors < 50)
			$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic void rearm_parser();
		ph       = fhvp_pkg::PH_TYPE;
		acc      = '0;
		acc_left = '0;
		seen_type = '0;
		seen_len = '0;
		hdr_cnt  = '0;
		pay_cnt  = '0;
		buf_cnt  = '0;
	endfunction

	function automatic fhvp_pkg::res_t decode_byte(input logic [7:0] b, input logic lst);
		fhvp_pkg::res_t        r;
		fhvp_pkg::byte_class_t cls;
		fhvp_pkg::status_t     st;
		r = '0;
		if (buf_cnt < fhvp_pkg::MAX_CNT)
			buf_cnt++;
		if (ph != fhvp_pkg::PH_BODY) begin
			if (ph == fhvp_pkg::PH_TYPE)
				cls = fhvp_pkg::CLS_TYPE;
			else
				cls = fhvp_pkg::CLS_LEN;
			if (hdr_cnt < fhvp_pkg::HDR_MAX)
				hdr_cnt++;
			if (acc_left == 3'd0) begin
				acc      = fhvp_pkg::ACC_W'(b & fhvp_pkg::VARINT_LOW_MASK);
				acc_left = 3'((4'd1 << b[7:6]) - 4'd1);
			end else begin
				acc      = {acc[fhvp_pkg::ACC_W-9:0], b};
				acc_left = acc_left - 3'd1;
			end
			if (acc_left == 3'd0) begin
				if (ph == fhvp_pkg::PH_TYPE) begin
					seen_type = acc[7:0];
					ph = fhvp_pkg::PH_LEN;
				end else begin
					seen_len = acc;
					ph = fhvp_pkg::PH_BODY;
				end
				acc = '0;
			end
		end else if (fhvp_pkg::ACC_W'(pay_cnt) < seen_len) begin
			cls = fhvp_pkg::CLS_PAYLOAD;
			if (pay_cnt < fhvp_pkg::MAX_CNT)
				pay_cnt++;
		end else begin
			cls = fhvp_pkg::CLS_TRAILING;
		end
		r.byte_class = cls;
		r.out_byte   = b;
		r.done_res   = lst;
		if (lst) begin
			if (buf_cnt < 2)
				st = fhvp_pkg::ST_SHORT;
			else if (ph != fhvp_pkg::PH_BODY)
				st = fhvp_pkg::ST_TRUNC;
			else if (seen_type != want_type)
				st = fhvp_pkg::ST_WRONG;
			else if (fhvp_pkg::ACC_W'(pay_cnt) < seen_len)
				st = fhvp_pkg::ST_MISMATCH;
			else
				st = fhvp_pkg::ST_OK;
			r.status         = st;
			r.frame_type     = (ph == fhvp_pkg::PH_TYPE) ? 8'h00 : seen_type;
			r.header_bytes   = hdr_cnt;
			r.payload_length = (ph == fhvp_pkg::PH_BODY) ? seen_len : '0;
			rearm_parser();
		end
		return r;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic lst, input bit typed,
		input fhvp_pkg::byte_class_t cls, input fhvp_pkg::status_t st,
		input logic [7:0] ft, input logic [fhvp_pkg::HDR_W-1:0] hl,
		input logic [fhvp_pkg::ACC_W-1:0] pl);
		stim_row_t row;
		row.b     = b;
		row.lst   = lst;
		row.typed = typed;
		row.want  = '{byte_class: cls, out_byte: b, done_res: lst, status: st,
			frame_type: ft, header_bytes: hl, payload_length: pl};
		dir_rows.push_back(row);
	endtask

	// Offers one byte, waits for its transfer and records the result it owes.
	task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
		input fhvp_pkg::res_t want);
		fhvp_pkg::res_t pred;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.last    <= lst;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pred = decode_byte(b, lst);
		results_due.push_back(typed ? want : pred);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (results_due.size() != 0);
	endtask

	task automatic write_expected_type(input logic [7:0] v);
		hold_until_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		want_type = v;
	endtask

	function automatic int varint_size();
		case ($urandom_range(3))
			0: return 1;
			1: return 2;
			2: return 4;
			default: return 8;
		endcase
	endfunction

	function automatic logic [63:0] size_mask(input int n);
		return (64'd1 << (8 * n - 2)) - 64'd1;
	endfunction

	task automatic push_varint(ref logic [7:0] q[$], input int n, input logic [63:0] v);
		logic [7:0] bt;
		logic [1:0] code;
		code = (n == 1) ? 2'd0 : (n == 2) ? 2'd1 : (n == 4) ? 2'd2 : 2'd3;
		for (int i = n - 1; i >= 0; i--) begin
			bt = v[8*i +: 8];
			if (i == n - 1)
				bt[7:6] = code;
			q.push_back(bt);
		end
	endtask

	// Mostly well-formed frames with random content; some are cut short,
	// carry a wrong type or length, or are plain noise.
	task automatic build_frame(ref logic [7:0] q[$]);
		int          n;
		int          plen;
		int          cut;
		bit          match;
		logic [63:0] v;
		logic [61:0] len;
		q.delete();
		if ($urandom_range(99) < 6) begin
			repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
			return;
		end
		match = ($urandom_range(99) < 75);
		n = varint_size();
		if (match && n == 1 && want_type > 8'd63)
			n = 2;
		v = {$urandom, $urandom} & size_mask(n);
		if (match) begin
			if (n == 1)
				v = 64'(want_type);
			else
				v[7:0] = want_type;
		end
		push_varint(q, n, v);
		n = varint_size();
		if ($urandom_range(99) < 90)
			v = 64'($urandom_range(0, 12));
		else
			v = {$urandom, $urandom} & size_mask(n);
		push_varint(q, n, v);
		len = v[61:0];
		if (len > 12)
			plen = $urandom_range(0, 6);
		else if ($urandom_range(99) < 70)
			plen = int'(len);
		else if ($urandom_range(99) < 50)
			plen = int'(len) + $urandom_range(1, 3);
		else
			plen = (len == 0) ? 0 : $urandom_range(0, int'(len) - 1);
		repeat (plen) q.push_back(8'($urandom));
		if ($urandom_range(99) < 10) begin
			cut = $urandom_range(1, q.size());
			while (q.size() > cut)
				void'(q.pop_back());
		end
	endtask

	always @(posedge clk)
		out_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin : check_results
		fhvp_pkg::res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("transfer with nothing expected", 64'(out_ch.out_byte), 0);
			end else begin
				want = results_due.pop_front();
				if (out_ch.byte_class != want.byte_class)
					report_mismatch("byte_class", 64'(out_ch.byte_class),
						64'(want.byte_class));
				if (out_ch.out_byte != want.out_byte)
					report_mismatch("out_byte", 64'(out_ch.out_byte), 64'(want.out_byte));
				if (out_ch.done_res != want.done_res)
					report_mismatch("done_res", 64'(out_ch.done_res), 64'(want.done_res));
				if (out_ch.status != want.status)
					report_mismatch("status", 64'(out_ch.status), 64'(want.status));
				if (out_ch.frame_type != want.frame_type)
					report_mismatch("frame_type", 64'(out_ch.frame_type),
						64'(want.frame_type));
				if (out_ch.header_bytes != want.header_bytes)
					report_mismatch("header_bytes", 64'(out_ch.header_bytes),
						64'(want.header_bytes));
				if (out_ch.payload_length != want.payload_length)
					report_mismatch("payload_length", 64'(out_ch.payload_length),
						64'(want.payload_length));
			end
		end
	end

	initial begin : stimulus
		logic [7:0] frame[$];
		int         phase_start;
		errors        = 0;
		items_sent    = 0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		want_type     = 8'h00;
		rearm_parser();
		arst_n        = 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 8'h00;
		in_ch.valid   <= 1'b0;
		in_ch.in_byte <= 8'h00;
		in_ch.last    <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed buffers, expected type still at its reset value.
		// A lone byte is too short.
		add_row(8'h00, 1, 1, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_SHORT, 8'h00, 1, 0);
		// Smallest complete frame: type 0, length 0.
		add_row(8'h00, 0, 1, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'h00, 1, 1, fhvp_pkg::CLS_LEN, fhvp_pkg::ST_OK, 8'h00, 2, 0);
		// One payload byte followed by one trailing byte.
		add_row(8'h00, 0, 0, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'h01, 0, 0, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'hAA, 0, 0, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'h55, 1, 0, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		// Header frame while data frames are expected.
		add_row(8'h01, 0, 1, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'h00, 1, 1, fhvp_pkg::CLS_LEN, fhvp_pkg::ST_WRONG, 8'h01, 2, 0);
		// Eight-byte type varint cut after two bytes.
		add_row(8'hC0, 0, 1, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'hFF, 1, 1, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_TRUNC, 8'h00, 2, 0);
		// Four-byte length varint cut after two bytes.
		add_row(8'h00, 0, 1, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'h80, 0, 1, fhvp_pkg::CLS_LEN, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'h12, 1, 1, fhvp_pkg::CLS_LEN, fhvp_pkg::ST_TRUNC, 8'h00, 3, 0);
		// Largest length value, with no payload behind it.
		add_row(8'h00, 0, 1, fhvp_pkg::CLS_TYPE, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		repeat (7) add_row(8'hFF, 0, 1, fhvp_pkg::CLS_LEN, fhvp_pkg::ST_OK, 8'h00, 0, 0);
		add_row(8'hFF, 1, 1, fhvp_pkg::CLS_LEN, fhvp_pkg::ST_MISMATCH, 8'h00, 9,
			{fhvp_pkg::ACC_W{1'b1}});

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 30;
					rx_idle_pct = 82;
					write_expected_type(8'h01);
				end
				1: begin
					tx_idle_pct = 82;
					rx_idle_pct = 30;
					write_expected_type(8'hFF);
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					write_expected_type(8'($urandom_range(2, 254)));
				end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < 300) begin
				build_frame(frame);
				foreach (frame[i]) begin
					// Now and then the sender stops mid-buffer until the
					// pipeline is empty.
					if (items_sent % 97 == 48)
						hold_until_drained();
					send_byte(frame[i], i == frame.size() - 1, 0, '0);
				end
			end
		end

		// Declared length 70000 with only 40 body bytes behind it: every
		// body byte stays payload and the length mismatches.
		write_expected_type(8'h00);
		frame.delete();
		frame.push_back(8'h00);
		push_varint(frame, 4, 64'd70000);
		repeat (40) frame.push_back(8'($urandom));
		foreach (frame[i])
			send_byte(frame[i], i == frame.size() - 1, 0, '0);

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("frame_header_varint_parser regression: pass");
		else
			$display("frame_header_varint_parser regression: fail");
		$finish;
	end

endmodule
